FILE: rtl/drsf_pkg.sv
// Shared types and constants of the DMX RGB slot fader.
// No dependencies; the controller, datapath and top refer to it by scoped names.
package drsf_pkg;

    // Item actions; the fourth code is unused and ignored
    typedef enum logic [1:0] {
        ACT_SET  = 2'd0,
        ACT_READ = 2'd1,
        ACT_TICK = 2'd2
    } t_action;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_SET,
        ST_READ,
        ST_TICK,
        ST_RESULT
    } t_state;

    // Datapath operating modes
    typedef enum logic [2:0] {
        DP_IDLE,
        DP_CLEAR,
        DP_SET,
        DP_READ,
        DP_TICK
    } t_dp_mode;

    localparam int LEVEL_W = 8;
    localparam int SLOT_W  = 10;

    // Command from controller to datapath
    typedef struct packed {
        logic     load;
        t_dp_mode mode;
        logic     out_load;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic       last;
        logic [1:0] action;
        logic       chan_ok;
        logic       out_free;
    } t_dp_sts;

endpackage

FILE: rtl/drsf_if.sv
// Valid/ready channel interfaces for the fader's items and results.
// No dependencies.
interface drsf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] channel;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, action, channel, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, action, channel, red_in, green_in, blue_in, output ready);
endinterface

interface drsf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [9:0] next_slot;
    logic       status;

    modport source (output valid, red_out, green_out, blue_out, next_slot, status, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, next_slot, status, output ready);
endinterface

FILE: rtl/drsf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module drsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/drsf_ctrl.sv
// Controller state machine of the slot fader: sequences clear, set, read and fade.
// Depends on drsf_pkg.
module drsf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  drsf_pkg::t_dp_sts i_sts,
    output drsf_pkg::t_dp_cmd o_cmd
);

    drsf_pkg::t_state r_state;
    drsf_pkg::t_state n_state;

    // State register; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= drsf_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            drsf_pkg::ST_CLEAR: begin
                if (i_sts.last) n_state = drsf_pkg::ST_IDLE;
            end
            drsf_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = drsf_pkg::ST_DISPATCH;
            end
            drsf_pkg::ST_DISPATCH: begin
                case (i_sts.action)
                    drsf_pkg::ACT_SET:
                        n_state = i_sts.chan_ok ? drsf_pkg::ST_SET : drsf_pkg::ST_RESULT;
                    drsf_pkg::ACT_READ:
                        n_state = i_sts.chan_ok ? drsf_pkg::ST_READ : drsf_pkg::ST_RESULT;
                    drsf_pkg::ACT_TICK:
                        n_state = drsf_pkg::ST_TICK;
                    default:
                        n_state = drsf_pkg::ST_RESULT;
                endcase
            end
            drsf_pkg::ST_SET, drsf_pkg::ST_READ, drsf_pkg::ST_TICK: begin
                if (i_sts.last) n_state = drsf_pkg::ST_RESULT;
            end
            drsf_pkg::ST_RESULT: begin
                if (i_sts.out_free) n_state = drsf_pkg::ST_IDLE;
            end
            default: n_state = drsf_pkg::ST_CLEAR;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd.load     = 1'b0;
        o_cmd.mode     = drsf_pkg::DP_IDLE;
        o_cmd.out_load = 1'b0;
        o_in_ready     = 1'b0;
        case (r_state)
            drsf_pkg::ST_CLEAR: o_cmd.mode = drsf_pkg::DP_CLEAR;
            drsf_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            drsf_pkg::ST_SET:    o_cmd.mode = drsf_pkg::DP_SET;
            drsf_pkg::ST_READ:   o_cmd.mode = drsf_pkg::DP_READ;
            drsf_pkg::ST_TICK:   o_cmd.mode = drsf_pkg::DP_TICK;
            drsf_pkg::ST_RESULT: o_cmd.out_load = i_sts.out_free;
            default: o_cmd.mode = drsf_pkg::DP_IDLE;
        endcase
    end

endmodule

FILE: rtl/drsf_datapath.sv
// Datapath of the slot fader: level memories, step counter, fade unit, result register.
// Depends on drsf_pkg and drsf_ram.
module drsf_datapath #(
    parameter int SLOT_COUNT = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    input  drsf_pkg::t_dp_cmd i_cmd,
    output drsf_pkg::t_dp_sts o_sts,
    input  logic [1:0]        i_action,
    input  logic [7:0]        i_channel,
    input  logic [7:0]        i_red,
    input  logic [7:0]        i_green,
    input  logic [7:0]        i_blue,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_red,
    output logic [7:0]        o_green,
    output logic [7:0]        o_blue,
    output logic [9:0]        o_next_slot,
    output logic              o_status
);

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int LW = drsf_pkg::LEVEL_W;
    localparam int SW = drsf_pkg::SLOT_W;

    localparam logic [CW-1:0] CNT_CLEAR_LAST = CW'(SLOT_COUNT - 1);
    localparam logic [CW-1:0] CNT_TICK_LAST  = CW'(SLOT_COUNT);
    localparam logic [CW-1:0] CNT_SET_LAST   = CW'(2);
    localparam logic [CW-1:0] CNT_READ_LAST  = CW'(3);
    localparam logic [SW-1:0] SLOT_MAX       = SW'(SLOT_COUNT - 1);

    logic [LW-1:0]   r_fade_rate;
    logic [1:0]      r_action;
    logic            r_chan_ok;
    logic [AW-1:0]   r_base;
    logic [SW-1:0]   r_prod;
    logic [LW-1:0]   r_red_in, r_green_in, r_blue_in;
    logic [LW-1:0]   r_red, r_green, r_blue;
    logic [CW-1:0]   r_cnt;
    logic            r_out_valid;
    logic [LW-1:0]   r_out_red, r_out_green, r_out_blue;
    logic [SW-1:0]   r_out_slot;
    logic            r_out_status;

    logic [SW-1:0]   w_prod;
    logic            w_chan_ok;
    logic            w_last;
    logic            w_read_ok;
    logic            w_out_free;
    logic [AW-1:0]   w_chan_addr;
    logic            w_cur_we, w_cur_re, w_tgt_we, w_tgt_re;
    logic [AW-1:0]   w_cur_waddr, w_cur_raddr, w_tgt_waddr;
    logic [LW-1:0]   w_cur_wdata, w_tgt_wdata;
    logic [LW-1:0]   w_cur_rdata, w_tgt_rdata;
    logic [LW-1:0]   w_fade;
    logic [LW-1:0]   w_diff;

    // Channel decode: first slot of channel c is 3c-2, last is 3c
    assign w_prod    = SW'({i_channel, 1'b0}) + SW'(i_channel);
    assign w_chan_ok = (i_channel != '0) && (w_prod <= SLOT_MAX);

    // Fade rate register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_rate <= '0;
        end else if (i_cfg_we) begin
            r_fade_rate <= i_cfg_wdata;
        end
    end

    // Latch the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action   <= i_action;
            r_chan_ok  <= w_chan_ok;
            r_base     <= AW'(w_prod - SW'(2));
            r_prod     <= w_prod;
            r_red_in   <= i_red;
            r_green_in <= i_green;
            r_blue_in  <= i_blue;
        end
    end

    // Step counter: advance in any active mode, wrap to zero on the last step
    always_comb begin
        case (i_cmd.mode)
            drsf_pkg::DP_CLEAR: w_last = (r_cnt == CNT_CLEAR_LAST);
            drsf_pkg::DP_SET:   w_last = (r_cnt == CNT_SET_LAST);
            drsf_pkg::DP_READ:  w_last = (r_cnt == CNT_READ_LAST);
            drsf_pkg::DP_TICK:  w_last = (r_cnt == CNT_TICK_LAST);
            default:            w_last = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.mode != drsf_pkg::DP_IDLE) begin
            r_cnt <= w_last ? '0 : r_cnt + CW'(1);
        end
    end

    assign w_chan_addr = AW'(r_base + AW'(r_cnt[1:0]));

    // Fade one slot toward its target, clamping at the target
    assign w_diff = (w_cur_rdata > w_tgt_rdata) ? (w_cur_rdata - w_tgt_rdata)
                                                : (w_tgt_rdata - w_cur_rdata);
    always_comb begin
        if (r_fade_rate == '0 || r_fade_rate >= w_diff) begin
            w_fade = w_tgt_rdata;
        end else if (w_cur_rdata > w_tgt_rdata) begin
            w_fade = w_cur_rdata - r_fade_rate;
        end else begin
            w_fade = w_cur_rdata + r_fade_rate;
        end
    end

    // Memory port steering
    always_comb begin
        w_cur_we    = 1'b0;
        w_cur_waddr = r_cnt[AW-1:0];
        w_cur_wdata = '0;
        w_cur_re    = 1'b0;
        w_cur_raddr = r_cnt[AW-1:0];
        w_tgt_we    = 1'b0;
        w_tgt_waddr = r_cnt[AW-1:0];
        w_tgt_wdata = '0;
        w_tgt_re    = 1'b0;
        case (i_cmd.mode)
            drsf_pkg::DP_CLEAR: begin
                w_cur_we = 1'b1;
                w_tgt_we = 1'b1;
            end
            drsf_pkg::DP_SET: begin
                w_tgt_we    = 1'b1;
                w_tgt_waddr = w_chan_addr;
                case (r_cnt[1:0])
                    2'd0:    w_tgt_wdata = r_red_in;
                    2'd1:    w_tgt_wdata = r_green_in;
                    default: w_tgt_wdata = r_blue_in;
                endcase
            end
            drsf_pkg::DP_READ: begin
                w_cur_re    = (r_cnt != CNT_READ_LAST);
                w_cur_raddr = w_chan_addr;
            end
            drsf_pkg::DP_TICK: begin
                // read slot n while writing back slot n-1
                w_cur_re    = (r_cnt != CNT_TICK_LAST);
                w_tgt_re    = (r_cnt != CNT_TICK_LAST);
                w_cur_we    = (r_cnt != '0);
                w_cur_waddr = AW'(r_cnt - CW'(1));
                w_cur_wdata = w_fade;
            end
            default: begin
                w_cur_we = 1'b0;
            end
        endcase
    end

    drsf_ram #(.WIDTH(LW), .DEPTH(SLOT_COUNT)) u_cur_ram (
        .i_clk   (i_clk),
        .i_we    (w_cur_we),
        .i_waddr (w_cur_waddr),
        .i_wdata (w_cur_wdata),
        .i_re    (w_cur_re),
        .i_raddr (w_cur_raddr),
        .o_rdata (w_cur_rdata)
    );

    drsf_ram #(.WIDTH(LW), .DEPTH(SLOT_COUNT)) u_tgt_ram (
        .i_clk   (i_clk),
        .i_we    (w_tgt_we),
        .i_waddr (w_tgt_waddr),
        .i_wdata (w_tgt_wdata),
        .i_re    (w_tgt_re),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (w_tgt_rdata)
    );

    // Capture read levels from the registered read port: red, green, then blue
    always_ff @(posedge i_clk) begin
        if (i_cmd.mode == drsf_pkg::DP_READ) begin
            case (r_cnt[1:0])
                2'd1:    r_red   <= w_cur_rdata;
                2'd2:    r_green <= w_cur_rdata;
                2'd3:    r_blue  <= w_cur_rdata;
                default: r_red   <= r_red;
            endcase
        end
    end

    // Result register
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_read_ok  = (r_action == drsf_pkg::ACT_READ) && r_chan_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_red   <= w_read_ok ? r_red   : '0;
            r_out_green <= w_read_ok ? r_green : '0;
            r_out_blue  <= w_read_ok ? r_blue  : '0;
            r_out_slot  <= w_read_ok ? r_prod + SW'(1) : '0;
            if (r_action == drsf_pkg::ACT_SET || r_action == drsf_pkg::ACT_READ) begin
                r_out_status <= !r_chan_ok;
            end else begin
                r_out_status <= (r_action != drsf_pkg::ACT_TICK);
            end
        end
    end

    assign o_sts.last     = w_last;
    assign o_sts.action   = r_action;
    assign o_sts.chan_ok  = r_chan_ok;
    assign o_sts.out_free = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_red       = r_out_red;
    assign o_green     = r_out_green;
    assign o_blue      = r_out_blue;
    assign o_next_slot = r_out_slot;
    assign o_status    = r_out_status;

endmodule

FILE: rtl/dmx_rgb_slot_fader.sv
// A frame tick fades every slot, one slot per cycle through the single read and write
// port of each level memory. The output register lets the next item be accepted while
// a result waits. Reset (synchronous, active low) starts a clearing pass that zeroes
// both level memories; no item is accepted during it, configuration writes are.
// Depends on drsf_pkg, drsf_if, modules.
module dmx_rgb_slot_fader #(
    parameter int SLOT_COUNT = 512
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [7:0]   i_cfg_wdata,
    drsf_in_if.sink      i_in,
    drsf_out_if.source   o_out
);

    drsf_pkg::t_dp_cmd w_cmd;
    drsf_pkg::t_dp_sts w_sts;

    // Controller
    drsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath
    drsf_datapath #(.SLOT_COUNT(SLOT_COUNT)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_action    (i_in.action),
        .i_channel   (i_in.channel),
        .i_red       (i_in.red_in),
        .i_green     (i_in.green_in),
        .i_blue      (i_in.blue_in),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_red       (o_out.red_out),
        .o_green     (o_out.green_out),
        .o_blue      (o_out.blue_out),
        .o_next_slot (o_out.next_slot),
        .o_status    (o_out.status)
    );

`ifndef ASSERT_OFF
    // No result is pending right after reset
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("result valid after reset");

    // One item at a time: no accept in the cycle after a transfer in
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted back to back");

    // An ignored item carries all-zero levels and slot
    a_ignored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status) |-> (o_out.red_out == '0 && o_out.green_out == '0
        && o_out.blue_out == '0 && o_out.next_slot == '0))
        else $error("ignored item with nonzero fields");

    // A reported next slot stays within the universe
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.next_slot <= 10'(SLOT_COUNT)))
        else $error("next slot out of range");
`endif

endmodule
